/* rtl/core/rpi_pkg.sv */
// Shared types and codes of the radial profile interpolator.
package rpi_pkg;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic [2:0] CSR_DIMENSIONS = 3'd0;
   localparam logic [2:0] CSR_CENTRE_X   = 3'd1;
   localparam logic [2:0] CSR_CENTRE_Y   = 3'd2;
   localparam logic [2:0] CSR_CENTRE_Z   = 3'd3;
   localparam logic [2:0] CSR_COUNT      = 3'd4;
   localparam logic [2:0] CSR_PRESSURE   = 3'd5;

   localparam logic [2:0] OP_DENSITY = 3'd0;
   localparam logic [2:0] OP_SILICON = 3'd1;
   localparam logic [2:0] OP_SULFUR  = 3'd2;
   localparam logic [2:0] OP_IRON    = 3'd3;
   localparam logic [2:0] OP_VEL_X   = 3'd4;
   localparam logic [2:0] OP_VEL_Y   = 3'd5;
   localparam logic [2:0] OP_VEL_Z   = 3'd6;

   typedef struct packed {
      logic        cmd;
      logic [7:0]  entry_index;
      logic [31:0] entry_radius;
      logic [31:0] entry_density;
      logic [15:0] entry_silicon;
      logic [15:0] entry_sulfur;
      logic [15:0] entry_iron;
      logic [32:0] off_x;
      logic [32:0] off_y;
      logic [32:0] off_z;
      logic [31:0] elapsed;
   } queue_item_type;

   typedef struct packed {
      logic [8:0]  entry_count;
      logic [31:0] pressure_factor;
   } back_cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ROOT,
      ST_SEARCH_RD,
      ST_SEARCH_CMP,
      ST_FETCH_LO,
      ST_FETCH_WAIT,
      ST_MUL_A,
      ST_MUL_B,
      ST_DIV,
      ST_PRESS,
      ST_FINISH
   } back_state_type;

endpackage

/* rtl/core/rpi_if.sv */
// Channel interfaces of the radial profile interpolator.
interface rpi_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [7:0]  entry_index;
   logic [31:0] entry_radius;
   logic [31:0] entry_density;
   logic [15:0] entry_silicon;
   logic [15:0] entry_sulfur;
   logic [15:0] entry_iron;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   logic [31:0] elapsed;
   modport source(output valid, cmd, entry_index, entry_radius, entry_density,
                  entry_silicon, entry_sulfur, entry_iron, pos_x, pos_y, pos_z,
                  elapsed, input ready);
   modport sink(input valid, cmd, entry_index, entry_radius, entry_density,
                entry_silicon, entry_sulfur, entry_iron, pos_x, pos_y, pos_z,
                elapsed, output ready);
endinterface

interface rpi_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [31:0] vel_x;
   logic signed [31:0] vel_y;
   logic signed [31:0] vel_z;
   logic [31:0] density;
   logic [31:0] pressure;
   logic        inside_marker;
   logic [15:0] frac_silicon;
   logic [15:0] frac_sulfur;
   logic [15:0] frac_iron;
   modport source(output valid, vel_x, vel_y, vel_z, density, pressure,
                  inside_marker, frac_silicon, frac_sulfur, frac_iron, input ready);
   modport sink(input valid, vel_x, vel_y, vel_z, density, pressure,
                inside_marker, frac_silicon, frac_sulfur, frac_iron, output ready);
endinterface

interface rpi_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

/* rtl/core/rpi_fifo.sv */
// Two-entry item queue between the front and back parts.
module rpi_fifo
   import rpi_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  queue_item_type  push_item,
   input  logic            pop,
   output queue_item_type  head_item,
   output fifo_status_type status
);

   queue_item_type entries_ff [2];
   logic           wr_ptr_ff;
   logic           rd_ptr_ff;
   logic [1:0]     count_ff;
   logic [1:0]     count_in;

   assign head_item    = entries_ff[rd_ptr_ff];
   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* rtl/core/rpi_front.sv */
// Front part: configuration registers, item intake and centre offsets.
module rpi_front
   import rpi_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   rpi_req_if.sink         req_ch,
   rpi_csr_if.sink         csr_ch,
   input  fifo_status_type fifo_status,
   output logic            push,
   output queue_item_type  push_item,
   output back_cfg_type    back_cfg
);

   logic [1:0]  dims_ff;
   logic [31:0] centre_x_ff;
   logic [31:0] centre_y_ff;
   logic [31:0] centre_z_ff;
   logic [8:0]  count_ff;
   logic [31:0] pressure_ff;

   assign csr_ch.ready = 1'b1;
   assign req_ch.ready = !fifo_status.full;
   assign push         = req_ch.valid && !fifo_status.full;

   assign back_cfg.entry_count     = count_ff;
   assign back_cfg.pressure_factor = pressure_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff     <= 2'd1;
         centre_x_ff <= 32'd0;
         centre_y_ff <= 32'd0;
         centre_z_ff <= 32'd0;
         count_ff    <= 9'd2;
         pressure_ff <= 32'd42950;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_DIMENSIONS: dims_ff     <= csr_ch.data[1:0];
            CSR_CENTRE_X:   centre_x_ff <= csr_ch.data;
            CSR_CENTRE_Y:   centre_y_ff <= csr_ch.data;
            CSR_CENTRE_Z:   centre_z_ff <= csr_ch.data;
            CSR_COUNT:      count_ff    <= csr_ch.data[8:0];
            CSR_PRESSURE:   pressure_ff <= csr_ch.data;
            default: ;
         endcase
      end
   end

   // Offsets are exact 33-bit differences; inactive axes contribute zero.
   always_comb begin
      push_item.cmd           = req_ch.cmd;
      push_item.entry_index   = req_ch.entry_index;
      push_item.entry_radius  = req_ch.entry_radius;
      push_item.entry_density = req_ch.entry_density;
      push_item.entry_silicon = req_ch.entry_silicon;
      push_item.entry_sulfur  = req_ch.entry_sulfur;
      push_item.entry_iron    = req_ch.entry_iron;
      push_item.elapsed       = req_ch.elapsed;
      push_item.off_x = {req_ch.pos_x[31], req_ch.pos_x} - {centre_x_ff[31], centre_x_ff};
      push_item.off_y = 33'd0;
      push_item.off_z = 33'd0;
      if (dims_ff > 2'd1) begin
         push_item.off_y = {req_ch.pos_y[31], req_ch.pos_y} - {centre_y_ff[31], centre_y_ff};
      end
      if (dims_ff > 2'd2) begin
         push_item.off_z = {req_ch.pos_z[31], req_ch.pos_z} - {centre_z_ff[31], centre_z_ff};
      end
   end

endmodule

/* rtl/core/rpi_back.sv */
// Back part: table store, squaring, square root, search, interpolation, division and pressure.
module rpi_back
   import rpi_pkg::*;
#(
   parameter int TABLE_DEPTH  = 256,
   parameter int TRACER_COUNT = 4
)
(
   input  logic           clock,
   input  logic           reset,
   input  queue_item_type item,
   input  logic           item_valid,
   output logic           pop,
   input  back_cfg_type   cfg,
   rpi_rsp_if.source      rsp_ch
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   back_state_type state_ff, state_in;

   logic [111:0] mem [TABLE_DEPTH];
   logic [111:0] rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic          mem_we;

   logic [32:0] offx_ff, offy_ff, offz_ff;
   logic [31:0] t_ff;
   logic [1:0]  ax_ff, part_ff;
   logic [65:0] sum_ff;
   logic        over_ff;
   logic [31:0] root_ff;
   logic [33:0] rrem_ff;
   logic [4:0]  iter_ff;
   logic [32:0] r_ff;
   logic [AW-1:0] l_ff;
   logic [111:0] hi_ff, lo_ff;
   logic        inside_ff;
   logic [2:0]  op_ff;
   logic [63:0] prod_ff;
   logic [32:0] drem_ff;
   logic [31:0] dlow_ff, dq_ff, dd_ff;
   logic        vneg_ff;
   logic [31:0] dens_ff, vx_ff, vy_ff, vz_ff;
   logic [15:0] si_ff, su_ff, fe_ff;

   logic        out_valid_ff;
   logic [31:0] out_vx_ff, out_vy_ff, out_vz_ff, out_dens_ff, out_press_ff;
   logic        out_inside_ff;
   logic [15:0] out_si_ff, out_su_ff, out_fe_ff;

   logic [31:0]   n_clamp;
   logic [AW-1:0] last_idx;
   logic          load_ok;
   logic          out_free;
   logic          out_load;

   // Squaring datapath.
   logic [32:0] sq_off, sq_mag;
   logic [16:0] mul_x, mul_y;
   logic [33:0] prod17;
   logic [65:0] sq_term, sum_nxt;
   logic        sq_last;

   // Square root step.
   logic [35:0] rt_rem2, rt_trial;
   logic        rt_take;
   logic [31:0] root_nxt;

   // Search and interpolation.
   logic        search_cont;
   logic [31:0] hi_rad, lo_rad, drp, drm, dspan;
   logic [31:0] a_sel, b_sel, m1, m2;
   logic [63:0] mul_out;
   logic [64:0] num;
   logic        is_vel_op;

   // Velocity setup.
   logic [32:0] v_off, v_mag;
   logic [48:0] v_div;
   logic        v_zero, v_sat;

   // Divider step.
   logic [33:0] dv_r2;
   logic        dv_take;
   logic [31:0] dv_q;
   logic [32:0] dv_rem;

   logic        res_we;
   logic [31:0] res_val;

   always_comb begin
      if (cfg.entry_count < 9'd2) begin
         n_clamp = 32'd2;
      end else if (32'(cfg.entry_count) > 32'(TABLE_DEPTH)) begin
         n_clamp = 32'(TABLE_DEPTH);
      end else begin
         n_clamp = 32'(cfg.entry_count);
      end
   end
   assign last_idx = AW'(n_clamp - 32'd1);
   assign load_ok  = (32'(item.entry_index) < 32'(TABLE_DEPTH));
   assign out_free = !out_valid_ff || rsp_ch.ready;

   always_comb begin
      case (ax_ff)
         2'd0:    sq_off = offx_ff;
         2'd1:    sq_off = offy_ff;
         default: sq_off = offz_ff;
      endcase
      sq_mag = sq_off[32] ? 33'(-sq_off) : sq_off;
      mul_x  = (part_ff == 2'd0) ? sq_mag[16:0] : {1'b0, sq_mag[32:17]};
      mul_y  = (part_ff == 2'd2) ? {1'b0, sq_mag[32:17]} : sq_mag[16:0];
      prod17 = {17'd0, mul_x} * {17'd0, mul_y};
      case (part_ff)
         2'd0:    sq_term = 66'(prod17);
         2'd1:    sq_term = 66'(prod17) << 18;
         default: sq_term = 66'(prod17) << 34;
      endcase
      sum_nxt = sum_ff + sq_term;
      sq_last = (ax_ff == 2'd2) && (part_ff == 2'd2);
   end

   always_comb begin
      rt_rem2  = {rrem_ff, sum_ff[63:62]};
      rt_trial = {2'b00, root_ff, 2'b01};
      rt_take  = (rt_rem2 >= rt_trial);
      root_nxt = {root_ff[30:0], rt_take};
   end

   assign search_cont = (l_ff != last_idx) && ({1'b0, rd_data_ff[111:80]} < r_ff);

   assign hi_rad    = hi_ff[111:80];
   assign lo_rad    = lo_ff[111:80];
   assign drp       = hi_rad - r_ff[31:0];
   assign drm       = r_ff[31:0] - lo_rad;
   assign dspan     = hi_rad - lo_rad;
   assign is_vel_op = (op_ff >= OP_VEL_X);

   always_comb begin
      case (op_ff)
         OP_SILICON: begin
            a_sel = {16'd0, lo_ff[47:32]};
            b_sel = {16'd0, hi_ff[47:32]};
         end
         OP_SULFUR: begin
            a_sel = {16'd0, lo_ff[31:16]};
            b_sel = {16'd0, hi_ff[31:16]};
         end
         OP_IRON: begin
            a_sel = {16'd0, lo_ff[15:0]};
            b_sel = {16'd0, hi_ff[15:0]};
         end
         default: begin
            a_sel = lo_ff[79:48];
            b_sel = hi_ff[79:48];
         end
      endcase
      // One shared 32x32 multiplier for both lerp terms and the pressure.
      case (state_ff)
         ST_MUL_A: begin
            m1 = a_sel;
            m2 = drp;
         end
         ST_MUL_B: begin
            m1 = b_sel;
            m2 = drm;
         end
         default: begin
            m1 = dens_ff;
            m2 = cfg.pressure_factor;
         end
      endcase
      mul_out = m1 * m2;
      num     = {1'b0, prod_ff} + {1'b0, mul_out};
   end

   always_comb begin
      case (op_ff)
         OP_VEL_X: v_off = offx_ff;
         OP_VEL_Y: v_off = offy_ff;
         default:  v_off = offz_ff;
      endcase
      v_mag  = v_off[32] ? 33'(-v_off) : v_off;
      v_div  = {v_mag, 16'd0};
      v_zero = (v_mag == 33'd0);
      // The quotient reaches 2^31 exactly when the top bits reach the divisor.
      v_sat  = (t_ff == 32'd0) || ({14'd0, v_div[48:31]} >= t_ff);
   end

   always_comb begin
      dv_r2   = {drem_ff, dlow_ff[31]};
      dv_take = (dv_r2 >= {2'b00, dd_ff});
      dv_q    = {dq_ff[30:0], dv_take};
      dv_rem  = dv_take ? 33'(dv_r2 - {2'b00, dd_ff}) : dv_r2[32:0];
   end

   always_comb begin
      res_we  = 1'b0;
      res_val = dv_q;
      if (state_ff == ST_MUL_A && is_vel_op && (v_zero || v_sat)) begin
         res_we  = 1'b1;
         res_val = v_zero ? 32'd0 : (v_off[32] ? 32'h8000_0000 : 32'h7FFF_FFFF);
      end else if (state_ff == ST_DIV && iter_ff == 5'd0) begin
         res_we  = 1'b1;
         res_val = (is_vel_op && vneg_ff) ? 32'(-dv_q) : dv_q;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid && item.cmd == CMD_QUERY) begin
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            if (sq_last) begin
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (iter_ff == 5'd0) begin
               state_in = ST_SEARCH_RD;
            end
         end
         ST_SEARCH_RD: state_in = ST_SEARCH_CMP;
         ST_SEARCH_CMP: begin
            if (search_cont) begin
               state_in = ST_SEARCH_RD;
            end else if (l_ff == last_idx) begin
               state_in = ST_PRESS;
            end else if (l_ff == '0) begin
               state_in = ST_MUL_A;
            end else begin
               state_in = ST_FETCH_LO;
            end
         end
         ST_FETCH_LO:   state_in = ST_FETCH_WAIT;
         ST_FETCH_WAIT: state_in = ST_MUL_A;
         ST_MUL_A: begin
            if (!is_vel_op) begin
               state_in = ST_MUL_B;
            end else if (!(v_zero || v_sat)) begin
               state_in = ST_DIV;
            end else if (op_ff == OP_VEL_Z) begin
               state_in = ST_PRESS;
            end
         end
         ST_MUL_B: state_in = ST_DIV;
         ST_DIV: begin
            if (iter_ff == 5'd0) begin
               state_in = (op_ff == OP_VEL_Z) ? ST_PRESS : ST_MUL_A;
            end
         end
         ST_PRESS: state_in = ST_FINISH;
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      pop      = 1'b0;
      mem_we   = 1'b0;
      out_load = 1'b0;
      rd_addr  = l_ff;
      unique case (state_ff)
         ST_IDLE: begin
            pop    = item_valid;
            mem_we = item_valid && item.cmd == CMD_LOAD && load_ok;
         end
         ST_FETCH_LO: rd_addr = l_ff - AW'(1);
         ST_FINISH:   out_load = out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[AW'(item.entry_index)] <= {item.entry_radius, item.entry_density,
                                        item.entry_silicon, item.entry_sulfur,
                                        item.entry_iron};
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            offx_ff <= item.off_x;
            offy_ff <= item.off_y;
            offz_ff <= item.off_z;
            t_ff    <= item.elapsed;
            ax_ff   <= 2'd0;
            part_ff <= 2'd0;
            sum_ff  <= 66'd0;
         end
         ST_SQUARE: begin
            sum_ff <= sum_nxt;
            if (part_ff == 2'd2) begin
               part_ff <= 2'd0;
               ax_ff   <= ax_ff + 2'd1;
            end else begin
               part_ff <= part_ff + 2'd1;
            end
            if (sq_last) begin
               over_ff <= (sum_nxt[65:64] != 2'd0);
               root_ff <= 32'd0;
               rrem_ff <= 34'd0;
               iter_ff <= 5'd31;
            end
         end
         ST_ROOT: begin
            rrem_ff <= rt_take ? 34'(rt_rem2 - rt_trial) : rt_rem2[33:0];
            root_ff <= root_nxt;
            sum_ff  <= sum_ff << 2;
            iter_ff <= iter_ff - 5'd1;
            if (iter_ff == 5'd0) begin
               r_ff <= over_ff ? 33'h1_0000_0000 : {1'b0, root_nxt};
               l_ff <= '0;
            end
         end
         ST_SEARCH_CMP: begin
            hi_ff     <= rd_data_ff;
            inside_ff <= (l_ff != last_idx);
            if (search_cont) begin
               l_ff <= l_ff + AW'(1);
            end else if (l_ff == last_idx) begin
               dens_ff <= rd_data_ff[79:48];
               vx_ff   <= 32'd0;
               vy_ff   <= 32'd0;
               vz_ff   <= 32'd0;
               si_ff   <= 16'd0;
               su_ff   <= 16'd0;
               fe_ff   <= 16'd0;
            end else if (l_ff == '0) begin
               // At or below the first radius, entry 0 is taken as is.
               dens_ff <= rd_data_ff[79:48];
               si_ff   <= rd_data_ff[47:32];
               su_ff   <= rd_data_ff[31:16];
               fe_ff   <= rd_data_ff[15:0];
               op_ff   <= OP_VEL_X;
            end
         end
         ST_FETCH_WAIT: begin
            lo_ff <= rd_data_ff;
            op_ff <= OP_DENSITY;
         end
         ST_MUL_A: begin
            prod_ff <= mul_out;
            vneg_ff <= v_off[32];
            if (is_vel_op) begin
               drem_ff <= {16'd0, v_div[48:32]};
               dlow_ff <= v_div[31:0];
               dd_ff   <= t_ff;
               iter_ff <= 5'd31;
            end
         end
         ST_MUL_B: begin
            drem_ff <= num[64:32];
            dlow_ff <= num[31:0];
            dd_ff   <= dspan;
            iter_ff <= 5'd31;
         end
         ST_DIV: begin
            drem_ff <= dv_rem;
            dlow_ff <= {dlow_ff[30:0], 1'b0};
            dq_ff   <= dv_q;
            iter_ff <= iter_ff - 5'd1;
         end
         ST_PRESS: prod_ff <= mul_out;
         default: ;
      endcase
      if (res_we) begin
         op_ff <= op_ff + 3'd1;
         case (op_ff)
            OP_DENSITY: dens_ff <= res_val;
            OP_SILICON: si_ff   <= res_val[15:0];
            OP_SULFUR:  su_ff   <= res_val[15:0];
            OP_IRON:    fe_ff   <= res_val[15:0];
            OP_VEL_X:   vx_ff   <= res_val;
            OP_VEL_Y:   vy_ff   <= res_val;
            default:    vz_ff   <= res_val;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_vx_ff     <= vx_ff;
         out_vy_ff     <= vy_ff;
         out_vz_ff     <= vz_ff;
         out_dens_ff   <= dens_ff;
         out_press_ff  <= prod_ff[63:32];
         out_inside_ff <= inside_ff && (TRACER_COUNT > 0);
         out_si_ff     <= (TRACER_COUNT > 1) ? si_ff : 16'd0;
         out_su_ff     <= (TRACER_COUNT > 2) ? su_ff : 16'd0;
         out_fe_ff     <= (TRACER_COUNT > 3) ? fe_ff : 16'd0;
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.vel_x         = out_vx_ff;
   assign rsp_ch.vel_y         = out_vy_ff;
   assign rsp_ch.vel_z         = out_vz_ff;
   assign rsp_ch.density       = out_dens_ff;
   assign rsp_ch.pressure      = out_press_ff;
   assign rsp_ch.inside_marker = out_inside_ff;
   assign rsp_ch.frac_silicon  = out_si_ff;
   assign rsp_ch.frac_sulfur   = out_su_ff;
   assign rsp_ch.frac_iron     = out_fe_ff;

endmodule

/* rtl/core/radial_profile_interpolator.sv */
// Top level of the radial profile interpolator.
//
//   channel  direction  carries
//   req_ch   in         load entry or query position and time
//   rsp_ch   out        velocities, density, pressure, marker, fractions
//   csr_ch   in         register index and write data, always ready
//
// A load is written from the idle state. A query squares the offsets, takes
// the square root and searches the table entry by entry; beyond the table it
// goes on to the pressure, at the first entry it runs the velocity divisions,
// and when interpolating the table divisions and then the velocity ones; a
// velocity that is zero or saturates skips its division. A result waiting to
// be taken holds the back part in its last state. Reset clears control state
// only; table entries are undefined until loaded, with no clearing pass. A
// two-item queue lets the front keep accepting while the back works.
module radial_profile_interpolator
   import rpi_pkg::*;
#(
   parameter int TABLE_DEPTH  = 256,
   parameter int TRACER_COUNT = 4
)
(
   input  logic      clock,
   input  logic      reset,
   rpi_req_if.sink   req_ch,
   rpi_rsp_if.source rsp_ch,
   rpi_csr_if.sink   csr_ch
);

   fifo_status_type fifo_status;
   queue_item_type  push_item;
   queue_item_type  head_item;
   back_cfg_type    back_cfg;
   logic            push;
   logic            pop;

   rpi_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .csr_ch      (csr_ch),
      .fifo_status (fifo_status),
      .push        (push),
      .push_item   (push_item),
      .back_cfg    (back_cfg)
   );

   rpi_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .status    (fifo_status)
   );

   rpi_back #(
      .TABLE_DEPTH  (TABLE_DEPTH),
      .TRACER_COUNT (TRACER_COUNT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item       (head_item),
      .item_valid (!fifo_status.empty),
      .pop        (pop),
      .cfg        (back_cfg),
      .rsp_ch     (rsp_ch)
   );

`ifndef NO_ASSERTIONS
   a_full_blocks_intake: assert property (@(posedge clock) disable iff (reset)
      fifo_status.full |-> !req_ch.ready)
      else $error("item accepted while the queue is full");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !fifo_status.empty)
      else $error("queue popped while empty");

   a_no_result_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_ch.valid)
      else $error("result offered right after reset");
`endif

endmodule

/* dv/tb_radial_profile_interpolator.sv */
// Self-checking testbench of the radial profile interpolator: table loads, queries, checks.
`timescale 1ns / 1ps

module tb_radial_profile_interpolator
   import rpi_pkg::*;
();

   localparam int          DEPTH      = 256;
   localparam logic [31:0] STEP       = 32'h0010_0000;
   localparam int          IDLE_LIMIT = 20000;

   typedef struct {
      logic        cmd;
      logic [7:0]  idx;
      logic [31:0] rad;
      logic [31:0] dens;
      logic [15:0] si;
      logic [15:0] su;
      logic [15:0] fe;
      logic [31:0] px;
      logic [31:0] py;
      logic [31:0] pz;
      logic [31:0] el;
   } profile_req_type;

   typedef struct {
      logic [31:0] vx;
      logic [31:0] vy;
      logic [31:0] vz;
      logic [31:0] dens;
      logic [31:0] press;
      logic        in_profile;
      logic [15:0] si;
      logic [15:0] su;
      logic [15:0] fe;
   } profile_rsp_type;

   class profile_scoreboard;
      bit [1:0]        dims;
      bit [31:0]       cx, cy, cz;
      bit [8:0]        count;
      bit [31:0]       pf;
      bit [31:0]       radius_mem[DEPTH];
      bit [31:0]       density_mem[DEPTH];
      bit [15:0]       si_mem[DEPTH];
      bit [15:0]       su_mem[DEPTH];
      bit [15:0]       fe_mem[DEPTH];
      profile_rsp_type expected_q[$];
      int              errors;

      function new();
         dims   = 1;
         cx     = 0;
         cy     = 0;
         cz     = 0;
         count  = 2;
         pf     = 42950;
         errors = 0;
      endfunction

      function void write_reg(logic [2:0] index, logic [31:0] data);
         case (index)
            CSR_DIMENSIONS: dims = data[1:0];
            CSR_CENTRE_X:   cx = data;
            CSR_CENTRE_Y:   cy = data;
            CSR_CENTRE_Z:   cz = data;
            CSR_COUNT:      count = data[8:0];
            CSR_PRESSURE:   pf = data;
            default: ;
         endcase
      endfunction

      // Offset over time, truncated toward zero and saturated to 32 signed bits.
      function bit [31:0] speed(longint off, bit [31:0] t);
         longint unsigned mag, q;
         bit              neg;
         neg = off < 0;
         mag = neg ? -off : off;
         if (mag == 0) return 0;
         if (t == 0) return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
         q = (mag << 16) / t;
         if (neg) return (q >= 64'h8000_0000) ? 32'h8000_0000 : 32'(0 - q);
         return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
      endfunction

      function bit [63:0] blend(bit [63:0] a, bit [63:0] b, bit [63:0] dp, bit [63:0] dm);
         return (a * dp + b * dm) / (dp + dm);
      endfunction

      function void note_item(profile_req_type it);
         longint          offs[3];
         longint unsigned m, n, res, b;
         bit [65:0]       sum;
         bit [32:0]       r;
         bit [63:0]       dp, dm, d;
         int              cnt, l;
         profile_rsp_type e;
         if (it.cmd == CMD_LOAD) begin
            radius_mem[it.idx]  = it.rad;
            density_mem[it.idx] = it.dens;
            si_mem[it.idx]      = it.si;
            su_mem[it.idx]      = it.su;
            fe_mem[it.idx]      = it.fe;
            return;
         end
         offs[0] = longint'($signed(it.px)) - longint'($signed(cx));
         offs[1] = (dims > 1) ? longint'($signed(it.py)) - longint'($signed(cy)) : 0;
         offs[2] = (dims > 2) ? longint'($signed(it.pz)) - longint'($signed(cz)) : 0;
         sum = 0;
         for (int k = 0; k < 3; k++) begin
            m = offs[k] < 0 ? -offs[k] : offs[k];
            sum += 66'(m * m);
         end
         if (sum[65:64] != 0) begin
            r = 33'h1_0000_0000;
         end else begin
            n   = sum[63:0];
            res = 0;
            b   = 64'h4000_0000_0000_0000;
            while (b > n) b >>= 2;
            while (b != 0) begin
               if (n >= res + b) begin
                  n -= res + b;
                  res = (res >> 1) + b;
               end else begin
                  res >>= 1;
               end
               b >>= 2;
            end
            r = res[32:0];
         end
         cnt = (count < 2) ? 2 : (count > DEPTH) ? DEPTH : count;
         l = 0;
         while (l < cnt - 1 && {1'b0, radius_mem[l]} < r) l++;
         e.in_profile = (l <= cnt - 2);
         e.si = 0;
         e.su = 0;
         e.fe = 0;
         e.vx = 0;
         e.vy = 0;
         e.vz = 0;
         if (!e.in_profile) begin
            d = density_mem[cnt - 1];
         end else begin
            if (l == 0) begin
               d    = density_mem[0];
               e.si = si_mem[0];
               e.su = su_mem[0];
               e.fe = fe_mem[0];
            end else begin
               dp   = radius_mem[l] - r;
               dm   = r - radius_mem[l - 1];
               d    = blend(density_mem[l - 1], density_mem[l], dp, dm);
               e.si = 16'(blend(si_mem[l - 1], si_mem[l], dp, dm));
               e.su = 16'(blend(su_mem[l - 1], su_mem[l], dp, dm));
               e.fe = 16'(blend(fe_mem[l - 1], fe_mem[l], dp, dm));
            end
            e.vx = speed(offs[0], it.el);
            e.vy = speed(offs[1], it.el);
            e.vz = speed(offs[2], it.el);
         end
         e.dens  = d[31:0];
         e.press = 32'((d * 64'(pf)) >> 32);
         expected_q.push_back(e);
      endfunction

      function void compare(string name, logic [31:0] e, logic [31:0] a);
         if (e !== a) begin
            errors++;
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, e, a);
         end
      endfunction

      function void check_result(profile_rsp_type got);
         profile_rsp_type e;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result: expected none, actual density %h",
                     $time, got.dens);
            return;
         end
         e = expected_q.pop_front();
         compare("vel_x", e.vx, got.vx);
         compare("vel_y", e.vy, got.vy);
         compare("vel_z", e.vz, got.vz);
         compare("density", e.dens, got.dens);
         compare("pressure", e.press, got.press);
         compare("inside_marker", 32'(e.in_profile), 32'(got.in_profile));
         compare("frac_silicon", 32'(e.si), 32'(got.si));
         compare("frac_sulfur", 32'(e.su), 32'(got.su));
         compare("frac_iron", 32'(e.fe), 32'(got.fe));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   quiet = 1'b0;
   int   idle_cycles = 0;

   rpi_req_if req_ch();
   rpi_rsp_if rsp_ch();
   rpi_csr_if csr_ch();

   profile_scoreboard sb = new();

   radial_profile_interpolator dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_ch.ready <= quiet || ($urandom_range(99) >= 10);
   end

   always @(posedge clock) begin
      profile_rsp_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.vx         = rsp_ch.vel_x;
         got.vy         = rsp_ch.vel_y;
         got.vz         = rsp_ch.vel_z;
         got.dens       = rsp_ch.density;
         got.press      = rsp_ch.pressure;
         got.in_profile = rsp_ch.inside_marker;
         got.si         = rsp_ch.frac_silicon;
         got.su         = rsp_ch.frac_sulfur;
         got.fe         = rsp_ch.frac_iron;
         sb.check_result(got);
      end
   end

   // Ends the run when nothing moves on any channel for too long.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_item(profile_req_type it);
      while (!quiet && $urandom_range(99) < 10) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.cmd           <= it.cmd;
      req_ch.entry_index   <= it.idx;
      req_ch.entry_radius  <= it.rad;
      req_ch.entry_density <= it.dens;
      req_ch.entry_silicon <= it.si;
      req_ch.entry_sulfur  <= it.su;
      req_ch.entry_iron    <= it.fe;
      req_ch.pos_x         <= it.px;
      req_ch.pos_y         <= it.py;
      req_ch.pos_z         <= it.pz;
      req_ch.elapsed       <= it.el;
      req_ch.valid         <= 1'b1;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note_item(it);
      @(negedge clock);
   endtask

   // Holds the sender until every expected result has come and the block is idle.
   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (sb.expected_q.size() != 0);
      repeat (50) @(posedge clock);
      @(negedge clock);
   endtask

   // The write strobe drops for one cycle so that writes never overlap in time.
   task automatic write_reg(logic [2:0] index, logic [31:0] data);
      csr_ch.index <= index;
      csr_ch.data  <= data;
      csr_ch.valid <= 1'b1;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      sb.write_reg(index, data);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
      @(negedge clock);
   endtask

   // A well-formed entry keeps the table ascending; a wild one takes any radius.
   function automatic profile_req_type load_item(int idx, bit wild);
      profile_req_type it;
      it     = '{default: '0};
      it.cmd = CMD_LOAD;
      it.idx = 8'(idx);
      it.rad = wild ? $urandom : idx * STEP + $urandom_range(STEP - 1);
      it.dens = $urandom;
      it.si  = 16'($urandom);
      it.su  = 16'($urandom);
      it.fe  = 16'($urandom);
      it.px  = $urandom;
      it.py  = $urandom;
      it.pz  = $urandom;
      it.el  = $urandom;
      return it;
   endfunction

   function automatic profile_req_type query_item(logic [31:0] x, logic [31:0] y,
                                                  logic [31:0] z, logic [31:0] el);
      profile_req_type it;
      it     = '{default: '0};
      it.cmd = CMD_QUERY;
      it.idx = 8'($urandom);
      it.rad = $urandom;
      it.dens = $urandom;
      it.px  = x;
      it.py  = y;
      it.pz  = z;
      it.el  = el;
      return it;
   endfunction

   // Queries land mostly within the table span around the centre, along x or a diagonal.
   function automatic profile_req_type random_query();
      logic [31:0] span, tgt, el;
      int          sel;
      span = ((sb.count < 2) ? 2 : (sb.count > DEPTH) ? DEPTH : sb.count) * STEP;
      sel  = $urandom_range(99);
      el   = (sel < 10) ? 32'h0 : (sel < 40) ? $urandom : $urandom_range(1, 32'h0010_0000);
      sel  = $urandom_range(99);
      if (sel < 15)
         return query_item($urandom, $urandom, $urandom, el);
      tgt = $urandom_range(span + span / 8);
      if ($urandom_range(1)) tgt = -tgt;
      if (sel < 70)
         return query_item(sb.cx + tgt, sb.cy + $urandom_range(STEP), sb.cz - STEP / 4, el);
      return query_item(sb.cx + tgt / 2, sb.cy + tgt / 2, sb.cz - tgt / 2, el);
   endfunction

   initial begin
      int cnt;
      req_ch.valid         = 1'b0;
      req_ch.cmd           = CMD_LOAD;
      req_ch.entry_index   = '0;
      req_ch.entry_radius  = '0;
      req_ch.entry_density = '0;
      req_ch.entry_silicon = '0;
      req_ch.entry_sulfur  = '0;
      req_ch.entry_iron    = '0;
      req_ch.pos_x         = '0;
      req_ch.pos_y         = '0;
      req_ch.pos_z         = '0;
      req_ch.elapsed       = '0;
      rsp_ch.ready         = 1'b0;
      csr_ch.valid         = 1'b0;
      csr_ch.index         = CSR_DIMENSIONS;
      csr_ch.data          = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Fill the whole table first so that no query reads an unwritten entry.
      for (int i = 0; i < DEPTH; i++) send_item(load_item(i, 1'b0));

      // Directed part under reset settings and then the register extremes.
      send_item(query_item(32'h0, 32'h0, 32'h0, 32'h0));
      send_item(query_item(sb.radius_mem[1], 32'h0, 32'h0, 32'hFFFF_FFFF));
      send_item(query_item(STEP / 2 + STEP / 4, 32'h0, 32'h0, 32'h1));
      send_item(query_item(-(STEP / 2 + STEP / 4), 32'h0, 32'h0, 32'h0));
      send_item(query_item(-(STEP / 2 + STEP / 4), 32'h0, 32'h0, 32'h1));
      send_item(query_item(32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0001_0000));
      send_item(query_item(32'h8000_0000, 32'h0, 32'h0, 32'h0001_0000));
      drain();
      write_reg(CSR_DIMENSIONS, 32'd3);
      write_reg(CSR_CENTRE_X, 32'h8000_0000);
      write_reg(CSR_CENTRE_Y, 32'h7FFF_FFFF);
      write_reg(CSR_CENTRE_Z, 32'h8000_0000);
      write_reg(CSR_PRESSURE, 32'hFFFF_FFFF);
      write_reg(CSR_COUNT, 32'd0);
      send_item(query_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1));
      send_item(query_item(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0));
      send_item(query_item(32'h8000_0000 + STEP, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1));
      drain();
      write_reg(CSR_COUNT, 32'd511);
      write_reg(CSR_PRESSURE, 32'h0);
      send_item(query_item(32'h8000_0000 + 32'h0800_0000, 32'h7FFF_FFFF - 32'h0800_0000,
                           32'h8000_0000, 32'h0002_0000));
      send_item(query_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h0001_0000));
      drain();
      write_reg(CSR_DIMENSIONS, 32'd0);
      write_reg(CSR_COUNT, 32'd1);
      send_item(query_item(32'h8000_0000 + STEP / 2, $urandom, $urandom, 32'h0000_8000));
      send_item(query_item(32'h8000_0000 + 3 * STEP, $urandom, $urandom, 32'h0000_8000));
      drain();

      // Random phases, each under its own settings; one runs with no idling.
      for (int ph = 0; ph < 8; ph++) begin
         write_reg(CSR_DIMENSIONS, ph % 4);
         write_reg(CSR_CENTRE_X, $urandom);
         write_reg(CSR_CENTRE_Y, $urandom);
         write_reg(CSR_CENTRE_Z, $urandom);
         write_reg(CSR_COUNT, (ph == 5) ? 32'd256 : $urandom_range(2, 16));
         write_reg(CSR_PRESSURE, (ph == 0) ? 32'h0 : (ph == 1) ? 32'hFFFF_FFFF : $urandom);
         quiet = (ph == 3);
         cnt   = (ph == 5) ? 120 : 260;
         for (int i = 0; i < cnt; i++) begin
            if ($urandom_range(99) < 30)
               send_item(load_item($urandom_range(DEPTH - 1), $urandom_range(99) < 5));
            else
               send_item(random_query());
         end
         drain();
      end
      quiet = 1'b0;

      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
